// File: design/led_matrix_interlaced_scan_assert.svh
// Assertion macros for the interlaced LED matrix scan driver.
// Used by the top level only; depends on nothing else.
`ifndef LED_MATRIX_INTERLACED_SCAN_ASSERT_SVH
`define LED_MATRIX_INTERLACED_SCAN_ASSERT_SVH
`ifndef SYNTHESIS
// Concurrent assertion on a given clock and active-low reset.
`define LMIS_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lmis assertion failed");
// Concurrent assertion on the block clock and reset.
`define LMIS_ASSERT(lbl, prop) `LMIS_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define LMIS_ASSERT_CLK(lbl, clk, rst_n, prop)
`define LMIS_ASSERT(lbl, prop)
`endif
`endif

// File: design/lmis_pkg.sv
// Package for the interlaced LED matrix scan driver.
// Holds the command and result beat types, codes and fixed constants; no dependencies.
`default_nettype none

package lmis_pkg;

  localparam int unsigned ROW_W           = 4;
  localparam int unsigned COL_W           = 4;
  localparam int unsigned PIX_W           = 2;
  localparam int unsigned PIXELS_PER_BYTE = 4;
  localparam int unsigned LINE_STEP       = 2;

  // Erased store byte: every pixel dark (active low).
  localparam logic [7:0] PIXEL_DARK = 8'hFF;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_SCAN  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_SHIFT = 1'b1
  } state_e;

  // Command beat.
  typedef struct packed {
    op_e        opcode;
    col_t       column;
    row_t       row_index;
    logic [7:0] pixel_byte;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic red_bit;
    logic green_bit;
    logic latch_last;
    row_t row_address;
  } res_t;

  // Write port of the frame store.
  typedef struct packed {
    logic       en;
    row_t       row;
    col_t       col;
    logic [7:0] data;
  } wr_req_t;

  // Read port of the frame store.
  typedef struct packed {
    logic en;
    row_t row;
    col_t col;
  } rd_req_t;

endpackage

`default_nettype wire

// File: design/led_matrix_interlaced_scan.sv
// Top level of the interlaced LED matrix scan driver.
// Depends on lmis_pkg, lmis_frame_store, lmis_scan_seq and the assertion header.
//
// Usage: a command beat on cmd_i is taken at a rising edge with start high and
// busy low. A write command (OP_WRITE) stores pixel_byte at column/row_index
// and gives no result; writes outside ROWS x BYTES_PER_ROW are dropped.
// A scan command (OP_SCAN) shifts out the current scan line: four result beats
// per byte, first byte first, one beat per cycle on res_o marked by res_valid_o.
// The last beat raises latch_last and carries the row address.
// The scan line then steps by two, all even rows first, then all odd rows.
// Timing: the first result beat passes the store's read register and then the
// result register before it is on res_o; busy stays high while the single
// pixel shift register sends one pixel pair per cycle; the next byte is fetched
// from the store's one read port during the last pixel. The latch beat comes in
// the first cycle with busy low.
// A write is taken in every cycle that busy is low.
// Reset clears the scan line to row zero and the valid bits of the store at
// once, so every byte reads as 0xFF (dark) until written; no clearing pass.
// The receiver cannot stall: each result beat is present for one cycle only.
`default_nettype none

`include "led_matrix_interlaced_scan_assert.svh"

module led_matrix_interlaced_scan #(
  parameter int unsigned ROWS          = 16,
  parameter int unsigned BYTES_PER_ROW = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire lmis_pkg::cmd_t cmd_i,
  output logic                busy,
  output logic                res_valid_o,
  output lmis_pkg::res_t      res_o
);

  logic              accept;
  logic              scan_start;
  lmis_pkg::wr_req_t wr_req;
  lmis_pkg::rd_req_t rd_req;
  logic [7:0]        rd_data;

  // Command decode.
  assign accept     = start && !busy;
  assign scan_start = accept && (cmd_i.opcode == lmis_pkg::OP_SCAN);

  assign wr_req.en   = accept && (cmd_i.opcode == lmis_pkg::OP_WRITE);
  assign wr_req.row  = cmd_i.row_index;
  assign wr_req.col  = cmd_i.column;
  assign wr_req.data = cmd_i.pixel_byte;

  lmis_frame_store #(
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr_req),
    .rd_i      (rd_req),
    .rd_data_o (rd_data)
  );

  lmis_scan_seq #(
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_start_i (scan_start),
    .rd_data_i    (rd_data),
    .rd_o         (rd_req),
    .busy_o       (busy),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  // A scan command always makes the block busy in the next cycle.
  `LMIS_ASSERT(a_scan_busy, scan_start |=> busy)
  // Every result beat follows a busy cycle.
  `LMIS_ASSERT(a_res_after_busy, res_valid_o |-> $past(busy))
  // The latch beat closes the line: the block is free again.
  `LMIS_ASSERT(a_latch_idle, (res_valid_o && res_o.latch_last) |-> !busy)
  // Row address is only driven on the latch beat.
  `LMIS_ASSERT(a_row_addr_zero,
               (res_valid_o && !res_o.latch_last) |-> (res_o.row_address == '0))

endmodule

`default_nettype wire

// File: design/lmis_frame_store.sv
// Frame store of the interlaced LED matrix scan driver: byte memory plus valid bits.
// Depends on lmis_pkg.
`default_nettype none

module lmis_frame_store #(
  parameter int unsigned ROWS          = 16,
  parameter int unsigned BYTES_PER_ROW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lmis_pkg::wr_req_t wr_i,
  input  wire lmis_pkg::rd_req_t rd_i,
  output logic [7:0]            rd_data_o
);

  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = ROWS * (1 << CW);
  localparam logic [lmis_pkg::ROW_W:0] ROWS_X = (lmis_pkg::ROW_W + 1)'(ROWS);
  localparam logic [lmis_pkg::COL_W:0] COLS_X = (lmis_pkg::COL_W + 1)'(BYTES_PER_ROW);

  logic [7:0]       mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       rd_data_q;
  logic             rd_valid_q;
  logic             wr_ok;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  // Writes outside the configured frame are dropped.
  assign wr_ok   = wr_i.en && ({1'b0, wr_i.row} < ROWS_X) && ({1'b0, wr_i.col} < COLS_X);
  assign wr_addr = {wr_i.row[RW-1:0], wr_i.col[CW-1:0]};
  assign rd_addr = {rd_i.row[RW-1:0], rd_i.col[CW-1:0]};

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q  <= mem_q[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
    end
  end

  // Valid bits: an entry never written reads as dark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_ok) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : lmis_pkg::PIXEL_DARK;

endmodule

`default_nettype wire

// File: design/lmis_scan_seq.sv
// Scan sequencer of the interlaced LED matrix driver: byte and pixel counters,
// the shared pixel shift register and the result register. Depends on lmis_pkg.
`default_nettype none

module lmis_scan_seq #(
  parameter int unsigned ROWS          = 16,
  parameter int unsigned BYTES_PER_ROW = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              scan_start_i,
  input  wire logic [7:0]        rd_data_i,
  output lmis_pkg::rd_req_t      rd_o,
  output logic                   busy_o,
  output logic                   res_valid_o,
  output lmis_pkg::res_t         res_o
);

  localparam int unsigned CW = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
  localparam logic [CW-1:0] BYTE_LAST = CW'(BYTES_PER_ROW - 1);
  localparam lmis_pkg::pix_t PIX_LAST = lmis_pkg::pix_t'(lmis_pkg::PIXELS_PER_BYTE - 1);
  localparam logic [lmis_pkg::ROW_W:0] ROWS_X = (lmis_pkg::ROW_W + 1)'(ROWS);
  localparam logic [lmis_pkg::ROW_W:0] STEP_X = (lmis_pkg::ROW_W + 1)'(lmis_pkg::LINE_STEP);

  lmis_pkg::state_e   state_q, state_d;
  logic [CW-1:0]      byte_q, byte_d;
  logic [CW-1:0]      byte_nx;
  lmis_pkg::pix_t     pix_q, pix_d;
  lmis_pkg::row_t     line_q, line_d;
  lmis_pkg::row_t     line_nx;
  logic [lmis_pkg::ROW_W:0] line_step;
  logic [7:0]         sr_q, sr_d;
  logic [7:0]         src;
  logic               last;
  logic               res_valid_q, res_valid_d;
  lmis_pkg::res_t     res_q, res_d;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmis_pkg::ST_IDLE;
      byte_q      <= '0;
      pix_q       <= '0;
      line_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      byte_q      <= byte_d;
      pix_q       <= pix_d;
      line_q      <= line_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Shift register and result payload.
  always_ff @(posedge clk_i) begin
    sr_q  <= sr_d;
    res_q <= res_d;
  end

  // Interlaced line advance: even rows, then odd rows, then back to zero.
  always_comb begin
    line_step = {1'b0, line_q} + STEP_X;
    if (line_step >= ROWS_X) begin
      line_nx = line_step[0] ? '0 : lmis_pkg::row_t'(1);
    end else begin
      line_nx = line_step[lmis_pkg::ROW_W-1:0];
    end
  end

  assign byte_nx = byte_q + CW'(1);
  // The first pixel of each byte comes straight from the store read.
  assign src  = (pix_q == '0) ? rd_data_i : sr_q;
  assign last = (byte_q == BYTE_LAST) && (pix_q == PIX_LAST);

  // Sequencer: one pixel pair per cycle, next byte fetched on the last pixel.
  always_comb begin
    state_d     = state_q;
    byte_d      = byte_q;
    pix_d       = pix_q;
    line_d      = line_q;
    sr_d        = sr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_o.en     = 1'b0;
    rd_o.row    = line_q;
    rd_o.col    = '0;
    unique case (state_q)
      lmis_pkg::ST_IDLE: begin
        if (scan_start_i) begin
          rd_o.en = 1'b1;
          byte_d  = '0;
          pix_d   = '0;
          state_d = lmis_pkg::ST_SHIFT;
        end
      end
      lmis_pkg::ST_SHIFT: begin
        sr_d                    = src >> lmis_pkg::PIX_W;
        res_valid_d             = 1'b1;
        res_d.red_bit           = src[0];
        res_d.green_bit         = src[1];
        res_d.latch_last        = last;
        res_d.row_address       = last ? line_q : '0;
        if (pix_q == PIX_LAST) begin
          pix_d = '0;
          if (last) begin
            line_d  = line_nx;
            state_d = lmis_pkg::ST_IDLE;
          end else begin
            byte_d   = byte_nx;
            rd_o.en  = 1'b1;
            rd_o.col = lmis_pkg::col_t'(byte_nx);
          end
        end else begin
          pix_d = pix_q + lmis_pkg::pix_t'(1);
        end
      end
      default: begin
        state_d = lmis_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q == lmis_pkg::ST_SHIFT);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
